@@ src/gle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types, constants and helpers for the GIF LZW encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

    localparam int HASH_ENTRIES  = 5003;
    localparam int MAX_CODE_BITS = 12;

    localparam int IDX_W   = $clog2(HASH_ENTRIES);
    localparam int CNT_W   = $clog2(HASH_ENTRIES + 1);
    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int NFC_W   = MAX_CODE_BITS + 1;
    localparam int KEY_W   = 1 + 8 + CODE_W;
    localparam int ENT_W   = KEY_W + CODE_W;
    localparam int ACC_W   = 24;
    localparam int BC_W    = 5;
    localparam int SIZE_W  = 4;
    localparam int DICT_SIZE = 1 << MAX_CODE_BITS;

    function automatic int hash_shift_f();
        int f;
        int k;
        f = HASH_ENTRIES;
        k = 0;
        for (int n = 0; n < 8; n++) begin
            if (f < 65536) begin
                f = f * 2;
                k = k + 1;
            end
        end
        return 8 - k;
    endfunction

    localparam int HASH_SHIFT = hash_shift_f();
    localparam int HX_W = (8 + HASH_SHIFT > MAX_CODE_BITS) ? 8 + HASH_SHIFT : MAX_CODE_BITS;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       final_pixel;
    } in_word_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       run_last;
        logic       stream_end;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_LOOK,
        ST_CMP,
        ST_PUT,
        ST_EMIT,
        ST_FLUSH,
        ST_MISS,
        ST_AFTER,
        ST_FIN2,
        ST_FIN3,
        ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        CSEL_PREFIX,
        CSEL_CLEAR,
        CSEL_END
    } csel_t;

    typedef struct packed {
        logic  load_item;
        logic  start_image;
        logic  look;
        logic  probe;
        logic  hit;
        logic  put;
        logic  emit_byte;
        logic  widen;
        logic  flush_done;
        logic  set_prefix;
        logic  dict_add;
        logic  dict_reset;
        logic  fin_done;
        logic  tail_out;
        logic  clr_step;
        csel_t csel;
    } cmd_t;

    typedef struct packed {
        logic key_hit;
        logic key_valid;
        logic probe_done;
        logic dict_full;
        logic bc_ge8;
        logic bc_nz;
        logic code_end;
        logic hold_valid;
        logic out_free;
        logic clr_last;
        logic fin;
    } sts_t;

    function automatic logic [SIZE_W-1:0] used_size(input logic [SIZE_W-1:0] m);
        logic [SIZE_W-1:0] r;
        r = m;
        if (r < SIZE_W'(2)) r = SIZE_W'(2);
        if (r > SIZE_W'(8)) r = SIZE_W'(8);
        if (r > SIZE_W'(MAX_CODE_BITS - 1)) r = SIZE_W'(MAX_CODE_BITS - 1);
        return r;
    endfunction

    function automatic logic [NFC_W-1:0] limit_for(input logic [SIZE_W-1:0] w);
        logic [NFC_W-1:0] r;
        if (w >= SIZE_W'(MAX_CODE_BITS)) begin
            r = NFC_W'(DICT_SIZE);
        end else begin
            r = (NFC_W'(1) << w) - NFC_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/gle_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gle_ctrl
// Sequencer: pixel lookup, code output, dictionary clear and step tail.
// ----------------------------------------------------------------------------
module gle_ctrl
    import gle_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    csel_t  csel_reg, csel_next;
    logic   first_seen_reg, first_seen_next;
    logic   clear_req_reg, clear_req_next;
    logic   have_slot_reg, have_slot_next;
    logic   byte_room;

    assign byte_room = !sts.hold_valid || sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            ret_reg        <= ST_IDLE;
            csel_reg       <= CSEL_PREFIX;
            first_seen_reg <= 1'b0;
            clear_req_reg  <= 1'b0;
            have_slot_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            csel_reg       <= csel_next;
            first_seen_reg <= first_seen_next;
            clear_req_reg  <= clear_req_next;
            have_slot_reg  <= have_slot_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        csel_next       = csel_reg;
        first_seen_next = first_seen_reg;
        clear_req_next  = clear_req_reg;
        have_slot_next  = have_slot_reg;
        cmd             = '0;
        cmd.csel        = csel_reg;
        s_ready         = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = first_seen_reg ? ST_LOOK : ST_START;
                end
            end
            ST_START: begin
                cmd.start_image = 1'b1;
                first_seen_next = 1'b1;
                csel_next       = CSEL_CLEAR;
                ret_next        = ST_AFTER;
                state_next      = ST_PUT;
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.key_hit) begin
                    cmd.hit    = 1'b1;
                    state_next = ST_AFTER;
                end else if (!sts.key_valid || sts.probe_done) begin
                    have_slot_next = !sts.key_valid;
                    csel_next      = CSEL_PREFIX;
                    ret_next       = ST_MISS;
                    state_next     = ST_PUT;
                end else begin
                    cmd.probe = 1'b1;
                end
            end
            ST_PUT: begin
                cmd.put    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.bc_ge8) begin
                    cmd.emit_byte = byte_room;
                end else begin
                    cmd.widen  = 1'b1;
                    state_next = sts.code_end ? ST_FLUSH : ret_reg;
                end
            end
            ST_FLUSH: begin
                // end code: drain the partial byte too
                if (sts.bc_nz) begin
                    cmd.emit_byte = byte_room;
                end else begin
                    cmd.flush_done = 1'b1;
                    state_next     = ret_reg;
                end
            end
            ST_MISS: begin
                cmd.set_prefix = 1'b1;
                if (!sts.dict_full) begin
                    cmd.dict_add = have_slot_reg;
                    state_next   = ST_AFTER;
                end else begin
                    cmd.dict_reset = 1'b1;
                    clear_req_next = 1'b1;
                    csel_next      = CSEL_CLEAR;
                    ret_next       = ST_AFTER;
                    state_next     = ST_PUT;
                end
            end
            ST_AFTER: begin
                if (sts.fin) begin
                    csel_next  = CSEL_PREFIX;
                    ret_next   = ST_FIN2;
                    state_next = ST_PUT;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_FIN2: begin
                csel_next  = CSEL_END;
                ret_next   = ST_FIN3;
                state_next = ST_PUT;
            end
            ST_FIN3: begin
                cmd.fin_done    = 1'b1;
                first_seen_next = 1'b0;
                clear_req_next  = 1'b1;
                state_next      = ST_TAIL;
            end
            ST_TAIL: begin
                if (byte_room) begin
                    cmd.tail_out   = 1'b1;
                    clear_req_next = 1'b0;
                    state_next     = clear_req_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_byte_without_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_byte |-> byte_room)
        else $error("byte emitted with no room");

    a_clear_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && sts.clr_last) |=> state_reg == ST_IDLE)
        else $error("clearing pass did not end");

    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_done |=> (clear_req_reg && !first_seen_reg))
        else $error("final pixel did not request a clear");
`endif

endmodule
`default_nettype wire

@@ src/gle_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gle_datapath
// Dictionary RAM, LZW code state, bit packer and output word register.
// ----------------------------------------------------------------------------
module gle_datapath
    import gle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire in_word_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data,
    input  wire logic        cfg_valid,
    input  wire logic [3:0]  cfg_data,
    input  wire cmd_t        cmd,
    output sts_t             sts
);

    localparam logic [IDX_W:0] H_X = (IDX_W + 1)'(HASH_ENTRIES);

    logic [ENT_W-1:0] mem [HASH_ENTRIES];
    logic [ENT_W-1:0] rd_reg;

    logic [SIZE_W-1:0] cfg_size_reg;
    logic [7:0]        pix_reg;
    logic              fin_reg;
    logic [SIZE_W-1:0] ls_reg;
    logic [7:0]        c_reg;
    logic [CODE_W-1:0] prefix_reg;
    logic [NFC_W-1:0]  nfc_reg;
    logic [SIZE_W-1:0] cw_reg;
    logic [NFC_W-1:0]  lim_reg;
    logic              cp_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [BC_W-1:0]   bc_reg;
    logic [CODE_W-1:0] code_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  disp_reg;
    logic [CNT_W-1:0]  pcnt_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic              hold_valid_reg;
    logic [7:0]        hold_byte_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic [SIZE_W-1:0] us;
    logic [7:0]        mask_us;
    logic [7:0]        mask_ls;
    logic [7:0]        c_now;
    logic [CODE_W-1:0] clr_code;
    logic [CODE_W-1:0] eoi_code;
    logic [HX_W-1:0]   hx;
    logic [IDX_W:0]    hx_x;
    logic [IDX_W-1:0]  hidx;
    logic [IDX_W:0]    cur_x;
    logic [IDX_W:0]    disp_x;
    logic [IDX_W-1:0]  pidx;
    logic [IDX_W-1:0]  mem_ra;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [ENT_W-1:0]  mem_wd;
    logic [CODE_W-1:0] code_sel;
    logic [CODE_W-1:0] code_m;
    logic [CODE_W-1:0] cw_mask;
    logic              out_free;
    logic              out_load;

    assign us       = used_size(cfg_size_reg);
    assign mask_us  = 8'((9'd1 << us) - 9'd1);
    assign mask_ls  = 8'((9'd1 << ls_reg) - 9'd1);
    assign c_now    = pix_reg & mask_ls;
    assign clr_code = CODE_W'(1) << ls_reg;
    assign eoi_code = clr_code + CODE_W'(1);

    // first probe: (pixel << shift) ^ prefix, folded once into the table
    assign hx   = (HX_W'(c_now) << HASH_SHIFT) ^ HX_W'(prefix_reg);
    assign hx_x = (IDX_W + 1)'(hx);
    assign hidx = IDX_W'((hx_x >= H_X) ? hx_x - H_X : hx_x);

    // later probes step back by the displacement, wrapping around
    assign cur_x  = (IDX_W + 1)'(idx_reg);
    assign disp_x = (IDX_W + 1)'(disp_reg);
    assign pidx   = IDX_W'((cur_x >= disp_x) ? cur_x - disp_x : cur_x + H_X - disp_x);

    assign mem_ra = cmd.look ? hidx : pidx;
    assign mem_we = cmd.dict_add || cmd.clr_step;
    assign mem_wa = cmd.clr_step ? clr_reg : idx_reg;
    assign mem_wd = cmd.clr_step ? '0 : {key_reg, nfc_reg[CODE_W-1:0]};

    always_comb begin
        case (cmd.csel)
            CSEL_PREFIX: code_sel = prefix_reg;
            CSEL_CLEAR:  code_sel = clr_code;
            CSEL_END:    code_sel = eoi_code;
            default:     code_sel = prefix_reg;
        endcase
    end

    assign cw_mask = CODE_W'((NFC_W'(1) << cw_reg) - NFC_W'(1));
    assign code_m  = code_sel & cw_mask;

    assign out_free = !out_valid_reg || m_ready;
    assign out_load = (cmd.emit_byte || cmd.tail_out) && hold_valid_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sts.key_hit    = rd_reg[ENT_W-1 -: KEY_W] == key_reg;
    assign sts.key_valid  = rd_reg[ENT_W-1];
    assign sts.probe_done = pcnt_reg == CNT_W'(HASH_ENTRIES);
    assign sts.dict_full  = nfc_reg >= NFC_W'(DICT_SIZE);
    assign sts.bc_ge8     = bc_reg >= BC_W'(8);
    assign sts.bc_nz      = bc_reg != '0;
    assign sts.code_end   = code_reg == eoi_code;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.out_free   = out_free;
    assign sts.clr_last   = clr_reg == IDX_W'(HASH_ENTRIES - 1);
    assign sts.fin        = fin_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            pix_reg <= s_data.pixel_value;
            fin_reg <= s_data.final_pixel;
        end
        if (cmd.look) begin
            c_reg    <= c_now;
            key_reg  <= {1'b1, c_now, prefix_reg};
            idx_reg  <= hidx;
            disp_reg <= (hidx == '0) ? IDX_W'(1) : IDX_W'(H_X - (IDX_W + 1)'(hidx));
            pcnt_reg <= '0;
        end
        if (cmd.probe) begin
            idx_reg  <= pidx;
            pcnt_reg <= pcnt_reg + CNT_W'(1);
        end
        if (cmd.put) code_reg <= code_m;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_size_reg   <= SIZE_W'(8);
            ls_reg         <= SIZE_W'(8);
            cw_reg         <= SIZE_W'(9);
            lim_reg        <= limit_for(SIZE_W'(9));
            nfc_reg        <= NFC_W'(258);
            cp_reg         <= 1'b0;
            prefix_reg     <= '0;
            acc_reg        <= '0;
            bc_reg         <= '0;
            clr_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) cfg_size_reg <= cfg_data;

            if (cmd.start_image) begin
                ls_reg     <= us;
                cw_reg     <= us + SIZE_W'(1);
                lim_reg    <= limit_for(us + SIZE_W'(1));
                nfc_reg    <= (NFC_W'(1) << us) + NFC_W'(2);
                cp_reg     <= 1'b0;
                acc_reg    <= '0;
                bc_reg     <= '0;
                prefix_reg <= CODE_W'(pix_reg & mask_us);
            end

            if (cmd.hit) prefix_reg <= rd_reg[CODE_W-1:0];
            if (cmd.set_prefix) prefix_reg <= CODE_W'(c_reg);
            if (cmd.fin_done) prefix_reg <= '0;

            if (cmd.dict_add) nfc_reg <= nfc_reg + NFC_W'(1);
            if (cmd.dict_reset) begin
                nfc_reg <= NFC_W'(clr_code) + NFC_W'(2);
                cp_reg  <= 1'b1;
            end

            if (cmd.put) begin
                acc_reg <= (acc_reg & ((ACC_W'(1) << bc_reg) - ACC_W'(1)))
                         | (ACC_W'(code_m) << bc_reg);
                bc_reg  <= bc_reg + BC_W'(cw_reg);
            end

            if (cmd.widen) begin
                if (cp_reg) begin
                    cw_reg  <= ls_reg + SIZE_W'(1);
                    lim_reg <= limit_for(ls_reg + SIZE_W'(1));
                    cp_reg  <= 1'b0;
                end else if (nfc_reg > lim_reg) begin
                    cw_reg  <= cw_reg + SIZE_W'(1);
                    lim_reg <= limit_for(cw_reg + SIZE_W'(1));
                end
            end

            if (cmd.flush_done) acc_reg <= '0;

            if (cmd.clr_step) begin
                clr_reg <= sts.clr_last ? '0 : clr_reg + IDX_W'(1);
            end

            // output word register: a loaded word waits here for the sink
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.emit_byte) begin
                acc_reg        <= acc_reg >> 8;
                bc_reg         <= (bc_reg >= BC_W'(8)) ? bc_reg - BC_W'(8) : '0;
                hold_byte_reg  <= acc_reg[7:0];
                hold_valid_reg <= 1'b1;
                if (hold_valid_reg) begin
                    out_reg <= '{code_byte: hold_byte_reg, run_last: 1'b0,
                                 stream_end: 1'b0};
                end
            end

            if (cmd.tail_out) begin
                hold_valid_reg <= 1'b0;
                if (hold_valid_reg) begin
                    out_reg <= '{code_byte: hold_byte_reg, run_last: 1'b1,
                                 stream_end: fin_reg};
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bc_reg <= BC_W'(MAX_CODE_BITS + 7))
        else $error("bit count out of range");

    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw_reg >= SIZE_W'(3)) && (cw_reg <= SIZE_W'(MAX_CODE_BITS)))
        else $error("code width out of range");

    a_next_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nfc_reg <= NFC_W'(DICT_SIZE))
        else $error("next free code past dictionary size");

    a_tail_empties_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tail_out |=> !hold_valid_reg)
        else $error("held byte left after step tail");
`endif

endmodule
`default_nettype wire

@@ src/gif_lzw_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_encoder
// GIF variable-width LZW encoder: palette pixels in, packed code bytes out.
// ----------------------------------------------------------------------------
//  channel  | ports                          | word
//  ---------+--------------------------------+-----------------------------
//  input    | s_valid s_ready s_data         | pixel_value, final_pixel
//  output   | m_valid m_ready m_data         | code_byte, run_last, stream_end
//  config   | cfg_valid cfg_ready cfg_data   | min_code_size (4 bits)
//
//  A pixel is hashed, read from the dictionary RAM and compared, again per
//  extra probe; each code sent is packed and emitted a byte at a time, a miss
//  adds an entry or sends a clear code, and the final pixel sends the end code.
//  After reset, after a full dictionary and after the final pixel, a clearing
//  pass runs with s_ready low; config is always taken. A full output register
//  stalls the packer until m_ready.
// ----------------------------------------------------------------------------
module gif_lzw_encoder
    import gle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_word_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    gle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gle_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

@@ tb/gif_lzw_checker.sv @@
// ----------------------------------------------------------------------------
// gif_lzw_checker
// Watches the pixel, byte and config channels of the GIF LZW encoder, keeps
// its own LZW dictionary and bit packer, and compares every byte word.
// ----------------------------------------------------------------------------
module gif_lzw_checker
    import gle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_word_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_word_t  m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output int         errors,
    output int         bytes_pending,
    output int         bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALID_BIT = 32'h0010_0000;

    int unsigned dict_key [HASH_ENTRIES];
    int unsigned dict_code[HASH_ENTRIES];
    int unsigned size_reg, cur_size, prefix, next_code, width, limit;
    int unsigned acc, nbits, shift;
    bit          clr_pend, in_image;
    out_word_t   byte_expect_q[$];
    out_word_t   step_bytes[$];

    function automatic int unsigned probe_shift();
        int unsigned f, k;
        f = HASH_ENTRIES;
        k = 0;
        while (f < 65536 && k < 8) begin
            f = f * 2;
            k++;
        end
        return 8 - k;
    endfunction

    function automatic int unsigned width_top(int unsigned nb);
        return (nb >= MAX_CODE_BITS) ? (1 << MAX_CODE_BITS) : (1 << nb) - 1;
    endfunction

    task automatic clear_dict();
        foreach (dict_key[i]) dict_key[i] = 0;
    endtask

    task automatic pack_code(int unsigned code);
        int unsigned eoi_code;
        out_word_t   w;
        eoi_code = (1 << cur_size) + 1;
        code = code & ((1 << width) - 1);
        acc = (acc & ((1 << nbits) - 1)) | (code << nbits);
        nbits += width;
        while (nbits >= 8) begin
            w = '0;
            w.code_byte = acc[7:0];
            step_bytes.push_back(w);
            acc = acc >> 8;
            nbits -= 8;
        end
        if (clr_pend) begin
            width = cur_size + 1;
            limit = width_top(width);
            clr_pend = 0;
        end else if (next_code > limit) begin
            width++;
            limit = width_top(width);
        end
        if (code == eoi_code) begin
            while (nbits > 0) begin
                w = '0;
                w.code_byte = acc[7:0];
                step_bytes.push_back(w);
                acc = acc >> 8;
                nbits = (nbits >= 8) ? nbits - 8 : 0;
            end
            acc = 0;
        end
    endtask

    task automatic begin_image();
        int unsigned m;
        m = size_reg;
        if (m < 2) m = 2;
        if (m > 8) m = 8;
        if (m > MAX_CODE_BITS - 1) m = MAX_CODE_BITS - 1;
        cur_size  = m;
        width     = m + 1;
        limit     = width_top(width);
        next_code = (1 << m) + 2;
        clr_pend  = 0;
        acc       = 0;
        nbits     = 0;
        clear_dict();
    endtask

    task automatic extend_string(int unsigned c);
        int unsigned key, idx, disp;
        bit          slot_ok;
        key = VALID_BIT | (c << MAX_CODE_BITS) | prefix;
        idx = ((c << shift) ^ prefix) % HASH_ENTRIES;
        slot_ok = 1;
        if (dict_key[idx] == key) begin
            prefix = dict_code[idx];
            return;
        end
        if (dict_key[idx] & VALID_BIT) begin
            // double-hash walk backwards until hit or an empty slot
            disp = (idx == 0) ? 1 : HASH_ENTRIES - idx;
            slot_ok = 0;
            for (int n = 0; n < HASH_ENTRIES; n++) begin
                idx = (idx >= disp) ? idx - disp : idx + HASH_ENTRIES - disp;
                if (dict_key[idx] == key) begin
                    prefix = dict_code[idx];
                    return;
                end
                if (!(dict_key[idx] & VALID_BIT)) begin
                    slot_ok = 1;
                    break;
                end
            end
        end
        pack_code(prefix);
        prefix = c;
        if (next_code < (1 << MAX_CODE_BITS)) begin
            if (slot_ok) begin
                dict_code[idx] = next_code;
                dict_key[idx]  = key;
                next_code++;
            end
        end else begin
            clear_dict();
            next_code = (1 << cur_size) + 2;
            clr_pend = 1;
            pack_code(1 << cur_size);
        end
    endtask

    task automatic encode_pixel(in_word_t px);
        int unsigned clr_val, c;
        step_bytes.delete();
        if (!in_image) begin
            begin_image();
            clr_val = 1 << cur_size;
            prefix = px.pixel_value & (clr_val - 1);
            pack_code(clr_val);
            in_image = 1;
        end else begin
            clr_val = 1 << cur_size;
            c = px.pixel_value & (clr_val - 1);
            extend_string(c);
        end
        if (px.final_pixel) begin
            pack_code(prefix);
            pack_code(clr_val + 1);
            in_image = 0;
            prefix = 0;
            clear_dict();
        end
        if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size()-1].run_last = 1'b1;
            if (px.final_pixel) step_bytes[step_bytes.size()-1].stream_end = 1'b1;
        end
        foreach (step_bytes[i]) byte_expect_q.push_back(step_bytes[i]);
    endtask

    assign bytes_pending = byte_expect_q.size();

    initial begin
        errors = 0;
        bytes_checked = 0;
        shift = probe_shift();
    end

    always @(posedge aclk) begin
        out_word_t exp_w;
        if (!aresetn) begin
            size_reg = 8;
            begin_image();
            prefix = 0;
            in_image = 0;
            byte_expect_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) size_reg = cfg_data;
            if (s_valid && s_ready) encode_pixel(s_data);
            if (m_valid && m_ready) begin
                bytes_checked++;
                if (byte_expect_q.size() == 0) begin
                    $error("unexpected byte word %h", m_data);
                    errors++;
                end else begin
                    exp_w = byte_expect_q.pop_front();
                    if (m_data.code_byte !== exp_w.code_byte) begin
                        $error("code_byte expected %h actual %h",
                               exp_w.code_byte, m_data.code_byte);
                        errors++;
                    end
                    if (m_data.run_last !== exp_w.run_last) begin
                        $error("run_last expected %b actual %b",
                               exp_w.run_last, m_data.run_last);
                        errors++;
                    end
                    if (m_data.stream_end !== exp_w.stream_end) begin
                        $error("stream_end expected %b actual %b",
                               exp_w.stream_end, m_data.stream_end);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_gif_lzw_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_gif_lzw_encoder
// Drives images of palette pixels and config writes into the LZW encoder
// under several idle/stall mixes; the checker judges the byte stream.
// ----------------------------------------------------------------------------
module tb_gif_lzw_encoder;
    import gle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 3_000_000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_word_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_word_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = 4'd8;

    int errors, bytes_pending, bytes_checked;
    int cycles = 0;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int pixels_sent = 0;
    int images_sent = 0;

    always #5 aclk = ~aclk;

    gif_lzw_encoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    gif_lzw_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .bytes_pending(bytes_pending),
        .bytes_checked(bytes_checked)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_ready <= ($urandom_range(99) >= m_idle_pct);
        if (cycles > LIMIT) begin
            $display("tb_gif_lzw_encoder: errors");
            $finish;
        end
    end

    // one pixel word; valid stays up across back-to-back words
    task automatic send_pixel(logic [7:0] pix, logic fin);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < s_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.pixel_value <= pix;
        s_data.final_pixel <= fin;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (fin) images_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_size(logic [3:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random image; low-color content half the time so strings get reused
    task automatic send_image(int len, bit full_range);
        logic [7:0] p;
        int unsigned span;
        span = full_range ? 255 : $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
            p = (i > 0 && $urandom_range(3) == 0) ? p : 8'($urandom_range(span));
            send_pixel(p, i == len - 1);
        end
    endtask

    initial begin
        logic [3:0] sizes[8] = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd1, 4'd3, 4'd9};
        int sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset size, lone pixels, extremes, masking at size 2
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        write_size(4'd2);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'haa, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'haa, 1'b0);
        send_pixel(8'h03, 1'b1);
        write_size(4'd0);
        send_pixel(8'd1, 1'b1);
        write_size(4'd15);
        send_image(8, 1);

        // longer image at full size: probe collisions
        write_size(4'd8);
        send_image(30, 1);

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin s_idle_pct = 0;  m_idle_pct = 0;  end
                1: begin s_idle_pct = 61; m_idle_pct = 0;  end
                2: begin s_idle_pct = 0;  m_idle_pct = 61; end
                default: begin s_idle_pct = 7; m_idle_pct = 7; end
            endcase
            for (int k = 0; k < 2; k++) begin
                write_size(sizes[(2 * ph + k) % 8]);
                for (int n = 0; n < 4; n++) begin
                    send_image($urandom_range(1, 25), 1'($urandom_range(1)));
                end
            end
        end
        drain();

        $display("covered %0d pixels in %0d images, %0d bytes checked",
                 pixels_sent, images_sent, bytes_checked);
        $display("min code sizes low, high and out of range, with stalls on both sides");
        if (errors == 0) begin
            $display("tb_gif_lzw_encoder: clean");
        end else begin
            $display("tb_gif_lzw_encoder: errors");
        end
        $finish;
    end

endmodule
